// ===== sv/risc_integer_instruction_executor_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer instruction executor
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef RISC_INTEGER_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define RISC_INTEGER_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication
`define RIE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RIE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rie_pkg.sv =====
// ----------------------------------------------------------------------------
// rie_pkg
// Shared types and instruction encodings of the integer instruction executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rie_pkg;

	localparam logic [31:0] RESET_PC_DEFAULT = 32'h0040_0000;
	localparam logic [31:0] REGION_MASK      = 32'hF000_0000;

	// primary opcodes
	localparam logic [5:0] OP_RTYPE = 6'd0;
	localparam logic [5:0] OP_J     = 6'd2;
	localparam logic [5:0] OP_JAL   = 6'd3;
	localparam logic [5:0] OP_BEQ   = 6'd4;
	localparam logic [5:0] OP_BNE   = 6'd5;
	localparam logic [5:0] OP_ADDI  = 6'd8;
	localparam logic [5:0] OP_ADDIU = 6'd9;
	localparam logic [5:0] OP_SLTI  = 6'd10;
	localparam logic [5:0] OP_SLTIU = 6'd11;
	localparam logic [5:0] OP_ORI   = 6'd13;
	localparam logic [5:0] OP_LUI   = 6'd15;
	localparam logic [5:0] OP_LW    = 6'd35;
	localparam logic [5:0] OP_SW    = 6'd43;

	// function codes of register-type instructions
	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_JR      = 6'd8;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_MFHI    = 6'd16;
	localparam logic [5:0] FN_MFLO    = 6'd18;
	localparam logic [5:0] FN_MULT    = 6'd24;
	localparam logic [5:0] FN_DIV     = 6'd26;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_ADDU    = 6'd33;
	localparam logic [5:0] FN_SUB     = 6'd34;
	localparam logic [5:0] FN_SUBU    = 6'd35;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_NOR     = 6'd39;
	localparam logic [5:0] FN_SLT     = 6'd42;
	localparam logic [5:0] FN_SLTU    = 6'd43;

	localparam logic [4:0] REG_SYS_CODE = 5'd2;
	localparam logic [4:0] REG_SYS_ARG  = 5'd4;
	localparam logic [4:0] REG_LINK     = 5'd31;

	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_SYSCALL = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_DIVZERO = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_EXEC = 8'b0000_0010,
		S_ITER = 8'b0000_0100,
		S_FIN  = 8'b0000_1000,
		S_ADDR = 8'b0001_0000,
		S_LOAD = 8'b0010_0000,
		S_SYS  = 8'b0100_0000,
		S_RET  = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		UOP_MUL = 2'd0,
		UOP_DIV = 2'd1,
		UOP_MOD = 2'd2
	} unit_op_t;

	typedef struct packed {
		logic [31:0] executed_pc;
		logic [31:0] next_pc;
		status_t     status;
		logic [31:0] syscall_code;
		logic [31:0] syscall_arg;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [31:0] mem_addr;
		logic [31:0] mem_data;
	} rie_result_t;

endpackage

`default_nettype wire

// ===== sv/rie_if.sv =====
// ----------------------------------------------------------------------------
// rie channel interfaces
// Valid/ready channels for instructions, results and the reset PC register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rie_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;
	modport source (output valid, output instruction_word, input ready);
	modport sink (input valid, input instruction_word, output ready);
endinterface

interface rie_result_if import rie_pkg::*; ();
	logic        valid;
	logic        ready;
	rie_result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rie_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/risc_integer_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// risc_integer_instruction_executor
// Executes one 32-bit integer instruction per transaction and reports effects.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time; instr.ready is high only while the
// sequencer is idle. Simple ALU ops, branches, jumps and mfhi/mflo pass
// through register read, execute and retire; syscall adds a step that
// captures registers 2 and 4, sw adds a data memory access step and lw an
// access and a load step. mult and div by a nonzero divisor run 32 steps on
// one shared 33-bit add/subtract unit plus a sign-fixup step. If MEM_WORDS
// is not a power of two, the word index of lw/sw is reduced modulo
// MEM_WORDS on that same unit. Writing the cfg channel loads the reset PC
// register and the program counter at once.
// A finished result sits in an output register; retire waits only if that
// register is still full.
`timescale 1ns / 1ps
`default_nettype none

`include "risc_integer_instruction_executor_defines.svh"

module risc_integer_instruction_executor import rie_pkg::*; #(
	parameter int MEM_WORDS = 1024
) (
	input  wire           clk,
	input  wire           arst_n,
	rie_instr_if.sink     instr,
	rie_cfg_if.sink       cfg,
	rie_result_if.source  result
);

	localparam int  IW       = $clog2(MEM_WORDS);
	localparam bit  MEM_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

	// control state
	state_t      state_q;
	logic        out_valid_q;
	logic [31:0] pc_q;
	logic [31:0] reset_pc_q;
	logic [31:0] rf_vld_q;
	rie_result_t out_q;

	// register file, HI/LO, data memory
	logic [31:0] rf_q [32];
	logic [31:0] rd_a_q, rd_b_q;
	logic [31:0] hi_q, lo_q;
	logic [31:0] dmem [MEM_WORDS];
	logic [31:0] mem_rd_q;
	logic [IW-1:0] idx_q;

	// instruction and pending results
	logic [31:0] ir_q;
	status_t     res_status_q;
	logic [31:0] res_npc_q;
	logic        res_wr_q;
	logic [4:0]  res_widx_q;
	logic [31:0] res_wval_q;
	logic        res_mw_q;
	logic [31:0] res_maddr_q;
	logic [31:0] res_mdata_q;
	logic [31:0] res_scode_q;
	logic [31:0] res_sarg_q;

	// shared iterative unit
	unit_op_t    uop_q;
	logic [31:0] acc_q, qr_q, m_q;
	logic [4:0]  cnt_q;
	logic        neg_q, negr_q;

	// decode
	logic [5:0]  opc, fn;
	logic [4:0]  sh;
	logic [31:0] a, b, imm, seq, ea;
	assign opc = ir_q[31:26];
	assign fn  = ir_q[5:0];
	assign sh  = ir_q[10:6];
	assign a   = rd_a_q;
	assign b   = rd_b_q;
	assign imm = {{16{ir_q[15]}}, ir_q[15:0]};
	assign seq = pc_q + 32'd4;
	assign ea  = a + imm;

	// read port addresses: fields of the arriving word, or 2/4 for syscall
	logic       rf_re;
	logic [4:0] ra, rb;
	assign rf_re = (state_q == S_IDLE && instr.valid) || (state_q == S_EXEC);
	assign ra = (state_q == S_IDLE) ? instr.instruction_word[25:21] : REG_SYS_CODE;
	assign rb = (state_q == S_IDLE) ? instr.instruction_word[20:16] : REG_SYS_ARG;

	// execute stage
	state_t      ex_next;
	status_t     ex_status;
	logic [31:0] ex_npc, ex_wval;
	logic        ex_wr, ex_mw, ex_ustart;
	logic [4:0]  ex_widx;
	unit_op_t    ex_uop;
	logic [31:0] ua, ub;

	assign ua = a[31] ? (32'd0 - a) : a;
	assign ub = b[31] ? (32'd0 - b) : b;

	always_comb begin
		ex_next   = S_RET;
		ex_status = ST_NORMAL;
		ex_npc    = seq;
		ex_wr     = 1'b0;
		ex_widx   = (opc == OP_RTYPE) ? ir_q[15:11] : ir_q[20:16];
		ex_wval   = '0;
		ex_mw     = 1'b0;
		ex_ustart = 1'b0;
		ex_uop    = UOP_MUL;
		if (opc == OP_RTYPE) begin
			ex_wr = 1'b1;
			case (fn)
				FN_ADD, FN_ADDU: ex_wval = a + b;
				FN_SUB, FN_SUBU: ex_wval = a - b;
				FN_AND:  ex_wval = a & b;
				FN_OR:   ex_wval = a | b;
				FN_NOR:  ex_wval = ~(a | b);
				FN_MFHI: ex_wval = hi_q;
				FN_MFLO: ex_wval = lo_q;
				FN_SLT:  ex_wval = {31'd0, $signed(a) < $signed(b)};
				FN_SLTU: ex_wval = {31'd0, a < b};
				FN_SLL:  ex_wval = b << sh;
				FN_SRL:  ex_wval = b >> sh;
				FN_MULT: begin
					ex_wr     = 1'b0;
					ex_ustart = 1'b1;
					ex_next   = S_ITER;
				end
				FN_DIV: begin
					ex_wr = 1'b0;
					if (b == 32'd0) begin
						ex_status = ST_DIVZERO;
					end else begin
						ex_ustart = 1'b1;
						ex_uop    = UOP_DIV;
						ex_next   = S_ITER;
					end
				end
				FN_JR: begin
					ex_wr  = 1'b0;
					ex_npc = a;
				end
				FN_SYSCALL: begin
					ex_wr     = 1'b0;
					ex_status = ST_SYSCALL;
					ex_next   = S_SYS;
				end
				default: begin
					ex_wr     = 1'b0;
					ex_status = ST_UNKNOWN;
				end
			endcase
		end else begin
			case (opc)
				OP_ADDI, OP_ADDIU: begin
					ex_wr   = 1'b1;
					ex_wval = ea;
				end
				OP_ORI: begin
					ex_wr   = 1'b1;
					ex_wval = a | {16'd0, ir_q[15:0]};
				end
				OP_LUI: begin
					ex_wr   = 1'b1;
					ex_wval = {ir_q[15:0], 16'd0};
				end
				OP_SLTI: begin
					ex_wr   = 1'b1;
					ex_wval = {31'd0, $signed(a) < $signed(imm)};
				end
				OP_SLTIU: begin
					ex_wr   = 1'b1;
					ex_wval = {31'd0, a < imm};
				end
				OP_BEQ: if (a == b) ex_npc = seq + {imm[29:0], 2'b00};
				OP_BNE: if (a != b) ex_npc = seq + {imm[29:0], 2'b00};
				OP_LW, OP_SW: begin
					ex_wr = (opc == OP_LW);
					ex_mw = (opc == OP_SW);
					if (MEM_POW2) begin
						ex_next = S_ADDR;
					end else begin
						ex_ustart = 1'b1;
						ex_uop    = UOP_MOD;
						ex_next   = S_ITER;
					end
				end
				OP_J: ex_npc = (seq & REGION_MASK) | {4'd0, ir_q[25:0], 2'b00};
				OP_JAL: begin
					ex_wr   = 1'b1;
					ex_widx = REG_LINK;
					ex_wval = seq;
					ex_npc  = (seq & REGION_MASK) | {4'd0, ir_q[25:0], 2'b00};
				end
				default: ex_status = ST_UNKNOWN;
			endcase
		end
	end

	// shared 33-bit adder: shift-add for multiply, restoring step for divide
	logic        is_mul;
	logic [32:0] ux, uy;
	logic [33:0] usum;
	assign is_mul = (uop_q == UOP_MUL);
	assign ux   = is_mul ? {1'b0, acc_q} : {acc_q, qr_q[31]};
	assign uy   = is_mul ? {1'b0, (qr_q[0] ? m_q : 32'd0)} : ~{1'b0, m_q};
	assign usum = {1'b0, ux} + {1'b0, uy} + {33'd0, ~is_mul};

	logic [63:0] prod_mag, prod;
	assign prod_mag = {acc_q, qr_q};
	assign prod     = neg_q ? (64'd0 - prod_mag) : prod_mag;

	// output slot free for retire
	logic retire;
	assign retire = (state_q == S_RET) && (!out_valid_q || result.ready);

	logic commit_wr;
	assign commit_wr = res_wr_q && (res_widx_q != 5'd0);

	assign instr.ready  = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			reset_pc_q  <= RESET_PC_DEFAULT;
			pc_q        <= RESET_PC_DEFAULT;
			rf_vld_q    <= '0;
		end else begin
			if (cfg.valid) begin
				reset_pc_q <= cfg.data;
				pc_q       <= cfg.data;
			end
			if (retire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (instr.valid) state_q <= S_EXEC;
				S_EXEC: state_q <= ex_next;
				S_ITER: if (cnt_q == 5'd0) state_q <= S_FIN;
				S_FIN:  state_q <= (uop_q == UOP_MOD) ? S_ADDR : S_RET;
				S_ADDR: state_q <= res_mw_q ? S_RET : S_LOAD;
				S_LOAD: state_q <= S_RET;
				S_SYS:  state_q <= S_RET;
				S_RET: begin
					if (retire) begin
						state_q <= S_IDLE;
						pc_q    <= res_npc_q;
						if (commit_wr) rf_vld_q[res_widx_q] <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// HI/LO: cleared at reset, loaded by mult and div in the fixup cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (state_q == S_FIN) begin
			case (uop_q)
				UOP_MUL: begin
					hi_q <= prod[63:32];
					lo_q <= prod[31:0];
				end
				UOP_DIV: begin
					lo_q <= neg_q ? (32'd0 - qr_q) : qr_q;
					hi_q <= negr_q ? (32'd0 - acc_q) : acc_q;
				end
				default: ;
			endcase
		end
	end

	// register file: two registered read ports, one write at retire
	always_ff @(posedge clk) begin
		if (rf_re) begin
			rd_a_q <= rf_vld_q[ra] ? rf_q[ra] : 32'd0;
			rd_b_q <= rf_vld_q[rb] ? rf_q[rb] : 32'd0;
		end
		if (retire && commit_wr) rf_q[res_widx_q] <= res_wval_q;
	end

	// data memory: one port, registered read
	always_ff @(posedge clk) begin
		if (state_q == S_ADDR) begin
			if (res_mw_q) dmem[idx_q] <= res_mdata_q;
			else mem_rd_q <= dmem[idx_q];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && instr.valid) ir_q <= instr.instruction_word;
		case (state_q)
			S_EXEC: begin
				res_status_q <= ex_status;
				res_npc_q    <= ex_npc;
				res_wr_q     <= ex_wr;
				res_widx_q   <= ex_widx;
				res_wval_q   <= ex_wval;
				res_mw_q     <= ex_mw;
				res_maddr_q  <= ex_mw ? ea : 32'd0;
				res_mdata_q  <= ex_mw ? b : 32'd0;
				res_scode_q  <= '0;
				res_sarg_q   <= '0;
				idx_q        <= ea[IW+1:2];
				if (ex_ustart) begin
					uop_q  <= ex_uop;
					acc_q  <= '0;
					cnt_q  <= 5'd31;
					neg_q  <= a[31] ^ b[31];
					negr_q <= a[31];
					if (ex_uop == UOP_MOD) begin
						qr_q <= {2'b00, ea[31:2]};
						m_q  <= 32'(MEM_WORDS);
					end else begin
						qr_q <= ua;
						m_q  <= ub;
					end
				end
			end
			S_ITER: begin
				cnt_q <= cnt_q - 5'd1;
				if (is_mul) begin
					acc_q <= usum[32:1];
					qr_q  <= {usum[0], qr_q[31:1]};
				end else begin
					acc_q <= usum[33] ? usum[31:0] : ux[31:0];
					qr_q  <= {qr_q[30:0], usum[33]};
				end
			end
			S_FIN: if (uop_q == UOP_MOD) idx_q <= acc_q[IW-1:0];
			S_LOAD: res_wval_q <= mem_rd_q;
			S_SYS: begin
				res_scode_q <= rd_a_q;
				res_sarg_q  <= rd_b_q;
			end
			default: ;
		endcase
		if (retire) begin
			out_q.executed_pc  <= pc_q;
			out_q.next_pc      <= res_npc_q;
			out_q.status       <= res_status_q;
			out_q.syscall_code <= res_scode_q;
			out_q.syscall_arg  <= res_sarg_q;
			out_q.reg_write    <= commit_wr;
			out_q.reg_index    <= commit_wr ? res_widx_q : 5'd0;
			out_q.reg_value    <= commit_wr ? res_wval_q : 32'd0;
			out_q.mem_write    <= res_mw_q;
			out_q.mem_addr     <= res_maddr_q;
			out_q.mem_data     <= res_mdata_q;
		end
	end

	// checks
	`RIE_ASSERT_NXT(a_accept_exec, clk, arst_n, instr.valid && instr.ready, state_q == S_EXEC, "accepted instruction did not enter execute")
	`RIE_ASSERT_NXT(a_retire_hold, clk, arst_n, state_q == S_RET && out_valid_q && !result.ready, state_q == S_RET, "retire left while output slot full")
	`RIE_ASSERT_IMP(a_no_r0_write, clk, arst_n, out_valid_q && out_q.reg_write, out_q.reg_index != 5'd0, "register zero reported as written")

endmodule

`default_nettype wire

// ===== tb/rie_checker.sv =====
// ----------------------------------------------------------------------------
// rie_checker
// Watches the instruction, reset-PC and result channels of the executor,
// keeps its own architectural state and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rie_checker import rie_pkg::*; #(
	parameter int MEM_WORDS = 1024
) (
	input  logic  clk,
	input  logic  arst_n,
	rie_instr_if  instr,
	rie_cfg_if    cfg,
	rie_result_if result,
	output int    errors,
	output int    pending
);

	logic [31:0] gpr [32];
	logic [31:0] hi_q, lo_q, pc_q, reset_pc_q;
	logic [31:0] dmem [MEM_WORDS];
	rie_result_t retire_q [$];

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic int word_slot(input logic [31:0] addr);
		return int'((addr >> 2) % MEM_WORDS);
	endfunction

	// architectural step: updates state, returns the retire record
	function automatic rie_result_t execute_instruction(input logic [31:0] iw);
		rie_result_t r;
		logic [5:0] opc, fn;
		logic [4:0] rs, rt, rd, sh;
		logic [31:0] a, b, imm, seq, ua, ub, q, rem;
		logic signed [63:0] prod;
		logic na, nb;
		opc = iw[31:26];
		fn  = iw[5:0];
		rs  = iw[25:21];
		rt  = iw[20:16];
		rd  = iw[15:11];
		sh  = iw[10:6];
		a   = gpr[rs];
		b   = gpr[rt];
		imm = sext16(iw[15:0]);
		seq = pc_q + 32'd4;
		r = '0;
		r.executed_pc = pc_q;
		r.next_pc = seq;
		r.status = ST_NORMAL;
		if (opc == OP_RTYPE) begin
			r.reg_write = 1'b1;
			r.reg_index = rd;
			case (fn)
				FN_ADD, FN_ADDU: r.reg_value = a + b;
				FN_SUB, FN_SUBU: r.reg_value = a - b;
				FN_AND: r.reg_value = a & b;
				FN_OR:  r.reg_value = a | b;
				FN_NOR: r.reg_value = ~(a | b);
				FN_MFHI: r.reg_value = hi_q;
				FN_MFLO: r.reg_value = lo_q;
				FN_SLT:  r.reg_value = {31'd0, $signed(a) < $signed(b)};
				FN_SLTU: r.reg_value = {31'd0, a < b};
				FN_SLL:  r.reg_value = b << sh;
				FN_SRL:  r.reg_value = b >> sh;
				FN_MULT: begin
					prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
					hi_q = prod[63:32];
					lo_q = prod[31:0];
					r.reg_write = 1'b0;
				end
				FN_DIV: begin
					r.reg_write = 1'b0;
					if (b == 32'd0) begin
						r.status = ST_DIVZERO;
					end else begin
						na = a[31];
						nb = b[31];
						ua = na ? -a : a;
						ub = nb ? -b : b;
						q = ua / ub;
						rem = ua % ub;
						lo_q = (na != nb) ? -q : q;
						hi_q = na ? -rem : rem;
					end
				end
				FN_JR: begin
					r.next_pc = a;
					r.reg_write = 1'b0;
				end
				FN_SYSCALL: begin
					r.status = ST_SYSCALL;
					r.syscall_code = gpr[REG_SYS_CODE];
					r.syscall_arg = gpr[REG_SYS_ARG];
					r.reg_write = 1'b0;
				end
				default: begin
					r.status = ST_UNKNOWN;
					r.reg_write = 1'b0;
				end
			endcase
		end else begin
			r.reg_index = rt;
			case (opc)
				OP_ADDI, OP_ADDIU: begin
					r.reg_write = 1'b1;
					r.reg_value = a + imm;
				end
				OP_ORI: begin
					r.reg_write = 1'b1;
					r.reg_value = a | {16'd0, iw[15:0]};
				end
				OP_LUI: begin
					r.reg_write = 1'b1;
					r.reg_value = {iw[15:0], 16'd0};
				end
				OP_SLTI: begin
					r.reg_write = 1'b1;
					r.reg_value = {31'd0, $signed(a) < $signed(imm)};
				end
				OP_SLTIU: begin
					r.reg_write = 1'b1;
					r.reg_value = {31'd0, a < imm};
				end
				OP_BEQ: if (a == b) r.next_pc = seq + (imm << 2);
				OP_BNE: if (a != b) r.next_pc = seq + (imm << 2);
				OP_LW: begin
					r.reg_write = 1'b1;
					r.reg_value = dmem[word_slot(a + imm)];
				end
				OP_SW: begin
					r.mem_write = 1'b1;
					r.mem_addr = a + imm;
					r.mem_data = b;
					dmem[word_slot(a + imm)] = b;
				end
				OP_J: r.next_pc = (seq & REGION_MASK) | {4'd0, iw[25:0], 2'd0};
				OP_JAL: begin
					r.reg_write = 1'b1;
					r.reg_index = REG_LINK;
					r.reg_value = seq;
					r.next_pc = (seq & REGION_MASK) | {4'd0, iw[25:0], 2'd0};
				end
				default: r.status = ST_UNKNOWN;
			endcase
		end
		// writes to register zero are dropped and reported as no write
		if (r.reg_write && r.reg_index != 5'd0) begin
			gpr[r.reg_index] = r.reg_value;
		end else begin
			r.reg_write = 1'b0;
			r.reg_index = '0;
			r.reg_value = '0;
		end
		pc_q = r.next_pc;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, actual %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rie_result_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) gpr[i] = '0;
			hi_q = '0;
			lo_q = '0;
			reset_pc_q = RESET_PC_DEFAULT;
			pc_q = RESET_PC_DEFAULT;
			retire_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				reset_pc_q = cfg.data;
				pc_q = cfg.data;
			end
			if (result.valid && result.ready) begin
				got = result.data;
				if (retire_q.size() == 0) begin
					$error("result transaction with no instruction outstanding");
					errors++;
				end else begin
					want = retire_q.pop_front();
					compare_field("executed_pc", want.executed_pc, got.executed_pc);
					compare_field("next_pc", want.next_pc, got.next_pc);
					compare_field("status", 32'(want.status), 32'(got.status));
					compare_field("syscall_code", want.syscall_code, got.syscall_code);
					compare_field("syscall_arg", want.syscall_arg, got.syscall_arg);
					compare_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
					compare_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
					compare_field("reg_value", want.reg_value, got.reg_value);
					compare_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
					compare_field("mem_addr", want.mem_addr, got.mem_addr);
					compare_field("mem_data", want.mem_data, got.mem_data);
				end
			end
			if (instr.valid && instr.ready)
				retire_q.push_back(execute_instruction(instr.instruction_word));
			pending = retire_q.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the integer instruction executor with directed and random
// instruction streams under several reset PC settings and random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import rie_pkg::*;

	localparam int PHASE_ITEMS = 400;
	localparam int STALL_LIMIT = 5000;  // cycles with no transaction at all

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	bit   calm;      // when set, neither side inserts gaps
	int   quiet_cycles;

	// word slots that a store with base register zero has written;
	// loads only ever read these, so no never-written word is read
	bit   stored [1024];
	int   stored_list [$];

	rie_instr_if  instr_ch ();
	rie_result_if result_ch ();
	rie_cfg_if    cfg_ch ();

	risc_integer_instruction_executor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	rie_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.instr   (instr_ch),
		.cfg     (cfg_ch),
		.result  (result_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly no gap, else a short one, now and then a long one
	function automatic int pick_gap();
		if (calm || $urandom_range(0, 2) != 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
		return $urandom_range(1, 3);
	endfunction

	// result side back-pressure
	int hold;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold <= 0;
		end else if (hold > 0) begin
			result_ch.ready <= 1'b0;
			hold <= hold - 1;
		end else begin
			result_ch.ready <= 1'b1;
			hold <= pick_gap();
		end
	end

	// watchdog: any transaction resets the count
	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// instruction encoders
	function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
		logic [4:0] rd, logic [4:0] sh);
		return {OP_RTYPE, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
		logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// one instruction transaction; valid stays high into a back-to-back item
	task automatic send_instr(input logic [31:0] iw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.instruction_word <= iw;
		// a store with base zero marks its slot as readable
		if (iw[31:26] == OP_SW && iw[25:21] == 5'd0 && !stored[iw[11:2]]) begin
			stored[iw[11:2]] = 1'b1;
			stored_list.push_back(int'(iw[11:2]));
		end
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
	endtask

	// reset PC write, only once the executor has drained
	task automatic load_reset_pc(input logic [31:0] value);
		instr_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [4:0] any_reg();
		return ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
	endfunction

	// random but well-formed instruction, with some raw noise
	function automatic logic [31:0] random_instr();
		logic [31:0] w;
		logic [15:0] imm;
		logic [4:0] rs, rt, rd, sh;
		logic [5:0] fns [17] = '{FN_SLL, FN_SRL, FN_JR, FN_SYSCALL, FN_MFHI, FN_MFLO,
			FN_MULT, FN_DIV, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_NOR,
			FN_SLT, FN_SLTU};
		logic [5:0] ops [9] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ORI, OP_LUI,
			OP_BEQ, OP_BNE, OP_J};
		w = $urandom();
		rs = any_reg();
		rt = any_reg();
		rd = any_reg();
		sh = 5'($urandom());
		imm = 16'($urandom());
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: return enc_r(fns[$urandom_range(0, 16)], rs, rt, rd,
				($urandom_range(0, 3) == 0) ? sh : 5'd0);
			6, 7, 8, 9, 10: return enc_i(ops[$urandom_range(0, 8)], rs, rt, imm);
			11: return {OP_JAL, w[25:0]};
			12, 13: return enc_i(OP_SW, ($urandom_range(0, 1) == 0) ? 5'd0 : rs, rt, imm);
			14, 15: begin
				if (stored_list.size() == 0) return enc_i(OP_SW, 5'd0, rt, imm);
				imm[11:2] = 10'(stored_list[$urandom_range(0, stored_list.size() - 1)]);
				return enc_i(OP_LW, 5'd0, rt, imm);
			end
			16: return {OP_RTYPE, w[25:6], fns[$urandom_range(0, 16)]};  // odd fields
			default: begin
				// raw word; a load that slipped in is turned into a store
				if (w[31:26] == OP_LW) w[31:26] = OP_SW;
				return w;
			end
		endcase
	endfunction

	initial begin
		logic [31:0] pcs [4];
		arst_n = 1'b0;
		calm = 1'b0;
		quiet_cycles = 0;
		instr_ch.valid <= 1'b0;
		instr_ch.instruction_word <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, many operations, special cases
		load_reset_pc(RESET_PC_DEFAULT);
		send_instr(enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF));
		send_instr(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF));         // r1 = all ones
		send_instr(enc_i(OP_LUI, 5'd0, 5'd2, 16'h8000));         // r2 = most negative
		send_instr(enc_i(OP_ADDI, 5'd0, 5'd3, 16'h7FFF));
		send_instr(enc_r(FN_ADD, 5'd2, 5'd1, 5'd5, 5'd0));       // wraps
		send_instr(enc_r(FN_SUBU, 5'd2, 5'd1, 5'd6, 5'd0));
		send_instr(enc_r(FN_NOR, 5'd2, 5'd3, 5'd7, 5'd0));
		send_instr(enc_r(FN_SLT, 5'd2, 5'd3, 5'd8, 5'd0));
		send_instr(enc_r(FN_SLTU, 5'd2, 5'd3, 5'd9, 5'd0));
		send_instr(enc_r(FN_SLL, 5'd0, 5'd1, 5'd10, 5'd31));
		send_instr(enc_r(FN_SRL, 5'd0, 5'd1, 5'd11, 5'd31));
		send_instr(enc_r(FN_MULT, 5'd2, 5'd2, 5'd0, 5'd0));
		send_instr(enc_r(FN_MFHI, 5'd0, 5'd0, 5'd12, 5'd0));
		send_instr(enc_r(FN_DIV, 5'd2, 5'd1, 5'd0, 5'd0));       // most negative / -1
		send_instr(enc_r(FN_MFLO, 5'd0, 5'd0, 5'd13, 5'd0));
		send_instr(enc_r(FN_DIV, 5'd3, 5'd0, 5'd0, 5'd0));       // divide by zero
		send_instr(enc_i(OP_SLTIU, 5'd0, 5'd14, 16'hFFFF));
		send_instr(enc_i(OP_SW, 5'd0, 5'd1, 16'h7FFC));
		send_instr(enc_i(OP_SW, 5'd0, 5'd2, 16'hFFFF));          // unaligned, wraps low
		send_instr(enc_i(OP_LW, 5'd0, 5'd15, 16'h7FFC));
		send_instr(enc_i(OP_ADDIU, 5'd1, 5'd0, 16'h0005));       // write to zero
		send_instr({OP_RTYPE, 20'hFFFFF, FN_SYSCALL});
		send_instr(enc_i(OP_BNE, 5'd1, 5'd0, 16'h8000));
		send_instr({OP_JAL, 26'h3FF_FFFF});
		send_instr(32'hFFFF_FFFF);                               // unknown opcode
		send_instr(enc_r(FN_JR, 5'd1, 5'd0, 5'd0, 5'd0));        // unaligned pc

		pcs = '{32'd0, 32'hFFFF_FFFC, RESET_PC_DEFAULT, {$urandom()} & 32'hFFFF_FFFC};
		foreach (pcs[p]) begin
			load_reset_pc(pcs[p]);
			calm = (p == 2);
			repeat (PHASE_ITEMS) send_instr(random_instr());
		end
		calm = 1'b0;
		instr_ch.valid <= 1'b0;

		// let the checker log the last accepted instruction before draining
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
